FILE: rtl/jtsc_pkg.sv
// shared constants and types for the json token syntax checker
package jtsc_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef enum logic [3:0] {
		TK_LBRACE = 4'd0,
		TK_RBRACE = 4'd1,
		TK_LBRACK = 4'd2,
		TK_RBRACK = 4'd3,
		TK_COLON  = 4'd4,
		TK_COMMA  = 4'd5,
		TK_STRING = 4'd6,
		TK_NUMBER = 4'd7,
		TK_BOOL   = 4'd8,
		TK_NULL   = 4'd9
	} token_kind_t;

	typedef enum logic [1:0] {
		VERDICT_BUSY    = 2'd0,
		VERDICT_VALID   = 2'd1,
		VERDICT_INVALID = 2'd2
	} verdict_t;

	// control from the grammar logic to the nesting stack
	typedef struct packed {
		logic             push;
		logic             obj;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] rd_idx;
	} stack_ctl_t;

endpackage

FILE: rtl/jtsc_nest_stack.sv
// nesting stack memory with a registered top-of-stack read and write forwarding
module jtsc_nest_stack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jtsc_pkg::stack_ctl_t   ctl,
	output logic                   top_obj
);

	logic mem [jtsc_pkg::MAX_DEPTH];
	logic rd_q;
	logic fwd_valid_q;
	logic fwd_obj_q;

	// read port always fetches the entry that will be on top next cycle
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[ctl.wr_idx] <= ctl.obj;
		end
		rd_q <= mem[ctl.rd_idx];
	end

	// a push writes the very entry being read, so the read returns stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= ctl.push;
		end
	end

	always_ff @(posedge clk) begin
		fwd_obj_q <= ctl.obj;
	end

	assign top_obj = fwd_valid_q ? fwd_obj_q : rd_q;

endmodule

FILE: rtl/json_token_syntax_checker_top.sv
// top level: json token grammar checker with nesting stack and output skid buffer
//
// Takes one lexed JSON token per beat and returns one result beat per token:
// verdict is busy until the token marked last, then valid or invalid, and
// error_seen goes high from the first grammar error on. A token is taken every
// cycle while the result side keeps up; the result path has an output register
// and one skid entry, so a token is still taken on the cycle a result first
// stalls. No token waits on the nesting stack: its top is read from
// a one-port-write, one-port-read memory whose registered read is aimed at the
// next top, with a push forwarded around the memory. Nesting up to MAX_DEPTH
// levels is held; an opening bracket beyond that is an error. The stack needs
// no clearing after reset, and the last token returns the grammar state to reset.
module json_token_syntax_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tok_valid,
	output logic       tok_stall,
	input  logic [3:0] token_kind,
	input  logic       last_token,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] verdict,
	output logic       error_seen
);

	typedef enum logic [2:0] {
		GS_TOP        = 3'd0,
		GS_KEY_OR_END = 3'd1,
		GS_COLON      = 3'd2,
		GS_VALUE      = 3'd3,
		GS_AFTER_VAL  = 3'd4,
		GS_KEY        = 3'd5,
		GS_VAL_OR_END = 3'd6,
		GS_DONE       = 3'd7
	} gs_t;

	gs_t                           state_q, state_d, adv_state;
	logic [jtsc_pkg::DEPTH_W-1:0]  depth_q, depth_d, adv_depth;
	logic                          error_q, error_d;
	logic                          in_obj;
	logic                          accept;
	logic                          is_open, is_scalar;
	logic                          legal, do_open, do_close, overflow;
	logic                          step_ok, advance, new_err, doc_ok;
	logic [1:0]                    res_verdict;
	logic                          res_err;
	jtsc_pkg::stack_ctl_t          stack_ctl;

	logic [1:0] out_verdict_q, skid_verdict_q;
	logic       out_err_q, skid_err_q;
	logic       out_valid_q, skid_valid_q;

	assign accept    = tok_valid && !tok_stall;
	assign is_open   = (token_kind == jtsc_pkg::TK_LBRACE) || (token_kind == jtsc_pkg::TK_LBRACK);
	assign is_scalar = token_kind inside {[jtsc_pkg::TK_STRING : jtsc_pkg::TK_NULL]};

	always_comb begin
		legal     = 1'b0;
		do_open   = 1'b0;
		do_close  = 1'b0;
		adv_state = state_q;
		case (state_q)
			GS_TOP: begin
				do_open = is_open;
				legal   = is_open;
			end
			GS_KEY_OR_END: begin
				if (token_kind == jtsc_pkg::TK_STRING) begin
					legal     = 1'b1;
					adv_state = GS_COLON;
				end else if (token_kind == jtsc_pkg::TK_RBRACE) begin
					legal    = 1'b1;
					do_close = 1'b1;
				end
			end
			GS_KEY: begin
				if (token_kind == jtsc_pkg::TK_STRING) begin
					legal     = 1'b1;
					adv_state = GS_COLON;
				end
			end
			GS_COLON: begin
				if (token_kind == jtsc_pkg::TK_COLON) begin
					legal     = 1'b1;
					adv_state = GS_VALUE;
				end
			end
			GS_VALUE, GS_VAL_OR_END: begin
				if (state_q == GS_VAL_OR_END && token_kind == jtsc_pkg::TK_RBRACK) begin
					legal    = 1'b1;
					do_close = 1'b1;
				end else if (is_open) begin
					legal   = 1'b1;
					do_open = 1'b1;
				end else if (is_scalar) begin
					legal     = 1'b1;
					adv_state = GS_AFTER_VAL;
				end
			end
			GS_AFTER_VAL: begin
				if (token_kind == jtsc_pkg::TK_COMMA) begin
					legal     = 1'b1;
					adv_state = in_obj ? GS_KEY : GS_VALUE;
				end else if ((in_obj && token_kind == jtsc_pkg::TK_RBRACE) ||
				             (!in_obj && token_kind == jtsc_pkg::TK_RBRACK)) begin
					legal    = 1'b1;
					do_close = 1'b1;
				end
			end
			default: begin
				legal = 1'b0;
			end
		endcase

		adv_depth = depth_q;
		if (do_open) begin
			adv_state = (token_kind == jtsc_pkg::TK_LBRACE) ? GS_KEY_OR_END : GS_VAL_OR_END;
			adv_depth = depth_q + 1'b1;
		end else if (do_close) begin
			adv_state = (depth_q == jtsc_pkg::DEPTH_W'(1)) ? GS_DONE : GS_AFTER_VAL;
			adv_depth = depth_q - 1'b1;
		end
	end

	assign overflow = do_open && (depth_q == jtsc_pkg::DEPTH_W'(jtsc_pkg::MAX_DEPTH));
	assign step_ok  = legal && !overflow;
	assign advance  = !error_q && step_ok;
	assign new_err  = error_q || !step_ok;
	assign doc_ok   = !new_err && (adv_state == GS_DONE);

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		error_d = error_q;
		if (accept) begin
			if (last_token) begin
				state_d = GS_TOP;
				depth_d = '0;
				error_d = 1'b0;
			end else if (advance) begin
				state_d = adv_state;
				depth_d = adv_depth;
			end else begin
				error_d = 1'b1;
			end
		end
	end

	always_comb begin
		if (last_token) begin
			res_verdict = doc_ok ? jtsc_pkg::VERDICT_VALID : jtsc_pkg::VERDICT_INVALID;
			res_err     = !doc_ok;
		end else begin
			res_verdict = jtsc_pkg::VERDICT_BUSY;
			res_err     = new_err;
		end
	end

	always_comb begin
		stack_ctl.push   = accept && advance && do_open;
		stack_ctl.obj    = (token_kind == jtsc_pkg::TK_LBRACE);
		stack_ctl.wr_idx = depth_q[jtsc_pkg::IDX_W-1:0];
		stack_ctl.rd_idx = jtsc_pkg::IDX_W'(depth_d - 1'b1);
	end

	jtsc_nest_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (stack_ctl),
		.top_obj (in_obj)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GS_TOP;
			depth_q <= '0;
			error_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			error_q <= error_d;
		end
	end

	// output register plus one skid entry
	assign tok_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				out_verdict_q <= skid_verdict_q;
				out_err_q     <= skid_err_q;
			end else begin
				out_verdict_q <= res_verdict;
				out_err_q     <= res_err;
			end
		end else if (accept) begin
			skid_verdict_q <= res_verdict;
			skid_err_q     <= res_err;
		end
	end

	assign res_valid  = out_valid_q;
	assign verdict    = out_verdict_q;
	assign error_seen = out_err_q;

endmodule
